// File: rtl/core/ssd4_pkg.sv
// Shared types, codes and constants for the four-digit seven-segment driver.
// No dependencies; every module of the block imports this package.
package ssd4_pkg;

   localparam int DIGIT_COUNT = 4;
   localparam int DIGIT_W     = $clog2(DIGIT_COUNT);
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] PAT_BLANK = 8'h00;
   localparam logic [7:0] PAT_MINUS = 8'h40;

   // largest value shown as digits is one below this; it and above show dashes
   localparam logic signed [15:0] DASH_VALUE = 16'sd9999;
   localparam logic signed [15:0] NEG_LIMIT  = -16'sd999;

   localparam logic [15:0]        LAG_RESET  = 16'd100;
   localparam logic [DIGIT_W-1:0] SCAN_RESET = DIGIT_W'(DIGIT_COUNT - 1);

   typedef enum logic [2:0] {
      CSR_REFRESH_LAG   = 3'd0,
      CSR_SEGMENT_LEVEL = 3'd1,
      CSR_DIGIT_LEVEL   = 3'd2,
      CSR_SCAN_DIR      = 3'd3,
      CSR_DISPLAY_EN    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_TICK      = 2'd0,
      KIND_LOAD_NUM  = 2'd1,
      KIND_LOAD_NEG  = 2'd2,
      KIND_LOAD_DASH = 2'd3
   } item_kind_type;

   typedef struct packed {
      logic               operation;
      logic signed [15:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]             segment_pins;
      logic [DIGIT_COUNT-1:0] digit_pins;
      logic [DIGIT_W-1:0]     digit_index;
   } rsp_payload_type;

   typedef struct packed {
      logic [15:0] refresh_lag;
      logic        segment_active_level;
      logic        digit_active_level;
      logic        scan_direction;
      logic        display_enable;
   } cfg_type;

   // classified item: magnitude and its decimal quotients by 10, 100, 1000
   typedef struct packed {
      item_kind_type kind;
      logic [13:0]   mag;
      logic [9:0]    quo10;
      logic [6:0]    quo100;
      logic [3:0]    quo1000;
   } work_type;

   function automatic logic [7:0] font_pattern(input logic [3:0] digit);
      logic [7:0] pat;
      case (digit)
         4'd0:    pat = 8'h3F;
         4'd1:    pat = 8'h06;
         4'd2:    pat = 8'h5B;
         4'd3:    pat = 8'h4F;
         4'd4:    pat = 8'h66;
         4'd5:    pat = 8'h6D;
         4'd6:    pat = 8'h7D;
         4'd7:    pat = 8'h07;
         4'd8:    pat = 8'h7F;
         4'd9:    pat = 8'h6F;
         default: pat = PAT_BLANK;
      endcase
      return pat;
   endfunction

endpackage

// File: rtl/core/ssd4_front.sv
// Front end: takes request beats, classifies them and splits the magnitude
// into decimal quotients by reciprocal multiplication. Uses ssd4_pkg.
module ssd4_front (
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ssd4_pkg::req_payload_type req_payload,
   input  logic                     queue_full,
   output logic                     push,
   output ssd4_pkg::work_type       push_data
);
   import ssd4_pkg::*;

   logic signed [15:0] value;
   logic               is_num;
   logic               is_neg;
   logic [15:0]        mag_full;
   logic [13:0]        mag;
   logic [29:0]        prod10;
   logic [29:0]        prod100;
   logic [29:0]        prod1000;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   assign value    = req_payload.value;
   assign is_num   = (value >= 16'sd0) && (value < DASH_VALUE);
   assign is_neg   = (value < 16'sd0) && (value >= NEG_LIMIT);
   assign mag_full = is_neg ? 16'(-value) : 16'(value);
   assign mag      = mag_full[13:0];

   // exact for mag below 10000
   assign prod10   = 30'(mag) * 30'd52429;
   assign prod100  = 30'(mag) * 30'd5243;
   assign prod1000 = 30'(mag) * 30'd8389;

   always_comb begin
      if (!req_payload.operation) begin
         push_data.kind = KIND_TICK;
      end else if (is_num) begin
         push_data.kind = KIND_LOAD_NUM;
      end else if (is_neg) begin
         push_data.kind = KIND_LOAD_NEG;
      end else begin
         push_data.kind = KIND_LOAD_DASH;
      end
      push_data.mag     = mag;
      push_data.quo10   = prod10[28:19];
      push_data.quo100  = prod100[25:19];
      push_data.quo1000 = prod1000[26:23];
   end

endmodule

// File: rtl/core/ssd4_queue.sv
// Short FIFO between front and back end. DEPTH must be a power of two >= 2.
// Uses ssd4_pkg for the entry type.
module ssd4_queue #(
   parameter int DEPTH = ssd4_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ssd4_pkg::work_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output ssd4_pkg::work_type pop_data
);
   import ssd4_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   work_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/ssd4_back.sv
// Back end: executes loads and ticks, holds patterns, prescaler, scan state
// and pin latch, and drives the response register. Uses ssd4_pkg.
module ssd4_back (
   input  logic                      clock,
   input  logic                      reset,
   input  ssd4_pkg::cfg_type         cfg,
   input  logic                      clear_pins,
   input  logic                      queue_not_empty,
   input  ssd4_pkg::work_type        queue_data,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ssd4_pkg::rsp_payload_type rsp_payload
);
   import ssd4_pkg::*;

   logic [7:0]             pattern_ff [DIGIT_COUNT];
   logic [15:0]            tick_count_ff;
   logic [DIGIT_W-1:0]     scan_pos_ff;
   logic [7:0]             latch_seg_ff;
   logic [DIGIT_COUNT-1:0] latch_dig_ff;
   logic [DIGIT_W-1:0]     driven_ff;
   logic                   rsp_valid_ff;
   rsp_payload_type        rsp_payload_ff;

   logic [7:0]             pattern_in [DIGIT_COUNT];
   logic [15:0]            tick_count_in;
   logic [DIGIT_W-1:0]     scan_pos_in;
   logic [7:0]             latch_seg_in;
   logic [DIGIT_COUNT-1:0] latch_dig_in;
   logic [DIGIT_W-1:0]     driven_in;
   rsp_payload_type        rsp_payload_in;

   logic [13:0] rem0;
   logic [9:0]  rem1;
   logic [6:0]  rem2;
   logic [3:0]  dig0, dig1, dig2, dig3;
   logic        blank3, blank2, blank1;
   logic [15:0] count_inc;
   logic [7:0]  seg_raw;
   logic [DIGIT_COUNT-1:0] dig_raw;

   assign pop         = queue_not_empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // remainders: x - 10*q as shift-add
   assign rem0 = queue_data.mag - (14'(queue_data.quo10) << 3)
                 - (14'(queue_data.quo10) << 1);
   assign rem1 = queue_data.quo10 - (10'(queue_data.quo100) << 3)
                 - (10'(queue_data.quo100) << 1);
   assign rem2 = queue_data.quo100 - (7'(queue_data.quo1000) << 3)
                 - (7'(queue_data.quo1000) << 1);
   assign dig0 = rem0[3:0];
   assign dig1 = rem1[3:0];
   assign dig2 = rem2[3:0];
   assign dig3 = queue_data.quo1000;

   // leading-zero blanking; negatives start the chain at digit 2
   assign blank3 = (queue_data.kind == KIND_LOAD_NUM) && (dig3 == 4'd0);
   assign blank2 = ((queue_data.kind == KIND_LOAD_NEG) || blank3) && (dig2 == 4'd0);
   assign blank1 = blank2 && (dig1 == 4'd0);

   assign count_inc = tick_count_ff + 16'd1;

   always_comb begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         pattern_in[i] = pattern_ff[i];
      end
      tick_count_in = tick_count_ff;
      scan_pos_in   = scan_pos_ff;
      latch_seg_in  = latch_seg_ff;
      latch_dig_in  = latch_dig_ff;
      driven_in     = driven_ff;

      case (queue_data.kind)
         KIND_LOAD_NUM, KIND_LOAD_NEG: begin
            pattern_in[0] = font_pattern(dig0);
            pattern_in[1] = blank1 ? PAT_BLANK : font_pattern(dig1);
            pattern_in[2] = blank2 ? PAT_BLANK : font_pattern(dig2);
            if (queue_data.kind == KIND_LOAD_NEG) begin
               pattern_in[3] = PAT_MINUS;
            end else begin
               pattern_in[3] = blank3 ? PAT_BLANK : font_pattern(dig3);
            end
         end
         KIND_LOAD_DASH: begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
               pattern_in[i] = PAT_MINUS;
            end
         end
         KIND_TICK: begin
            if (cfg.display_enable) begin
               if (count_inc > cfg.refresh_lag) begin
                  tick_count_in = '0;
                  latch_seg_in  = pattern_ff[scan_pos_ff];
                  latch_dig_in  = DIGIT_COUNT'(1) << scan_pos_ff;
                  driven_in     = scan_pos_ff;
                  scan_pos_in   = cfg.scan_direction ? scan_pos_ff + DIGIT_W'(1)
                                                     : scan_pos_ff - DIGIT_W'(1);
               end else begin
                  tick_count_in = count_inc;
               end
            end
         end
         default: begin
         end
      endcase

      seg_raw = cfg.display_enable ? latch_seg_in : '0;
      dig_raw = cfg.display_enable ? latch_dig_in : '0;
      rsp_payload_in.segment_pins = cfg.segment_active_level ? seg_raw : ~seg_raw;
      rsp_payload_in.digit_pins   = cfg.digit_active_level ? dig_raw : ~dig_raw;
      rsp_payload_in.digit_index  = driven_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            pattern_ff[i] <= PAT_BLANK;
         end
         tick_count_ff <= '0;
         scan_pos_ff   <= SCAN_RESET;
         latch_seg_ff  <= '0;
         latch_dig_ff  <= '0;
         driven_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (clear_pins) begin
            latch_seg_ff <= '0;
            latch_dig_ff <= '0;
         end else if (pop) begin
            latch_seg_ff <= latch_seg_in;
            latch_dig_ff <= latch_dig_in;
         end
         if (pop) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
               pattern_ff[i] <= pattern_in[i];
            end
            tick_count_ff <= tick_count_in;
            scan_pos_ff   <= scan_pos_in;
            driven_ff     <= driven_in;
            rsp_valid_ff  <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

endmodule

// File: rtl/core/seven_segment_four_digit_driver_core.sv
// Four-digit seven-segment display driver, top level.
// Depends on ssd4_pkg, ssd4_front, ssd4_queue and ssd4_back.
//
// Usage:
//   req_* carries one beat per item: operation 1 loads a signed value into
//   the four digit patterns, operation 0 is a refresh tick that advances the
//   prescaler and, once the count passes refresh_lag, drives the next digit.
//   rsp_* returns one beat per item with the segment pins, digit enables and
//   the driven digit index as they stand after that item.
//   csr_* writes a register by index: 0 refresh_lag, 1 segment level,
//   2 digit level, 3 scan direction, 4 display enable. Write only while idle.
// Timing:
//   An accepted item is written into the queue at the accept edge and, once
//   the back end pops it, lands in the response register. One item per cycle
//   sustained while rsp_stall is low; the front end is combinational and the
//   back end takes one queued item per pop. A stalled rsp beat holds; the
//   queue absorbs up to QUEUE_DEPTH more items before req_stall rises.
// Reset: patterns blank, prescaler zero, scan starts at digit 3, pins off,
//   registers at their defaults, no response pending.
module seven_segment_four_digit_driver_core #(
   parameter int QUEUE_DEPTH = ssd4_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ssd4_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ssd4_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_write_enable,
   input  logic [2:0]                csr_index,
   input  logic [15:0]               csr_write_data
);
   import ssd4_pkg::*;

   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   logic     clear_pins;
   logic     queue_full;
   logic     queue_not_empty;
   logic     push;
   logic     pop;
   work_type push_data;
   work_type pop_data;

   always_comb begin
      cfg_in     = cfg_ff;
      clear_pins = 1'b0;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_REFRESH_LAG:   cfg_in.refresh_lag          = csr_write_data;
            CSR_SEGMENT_LEVEL: cfg_in.segment_active_level = csr_write_data[0];
            CSR_DIGIT_LEVEL:   cfg_in.digit_active_level   = csr_write_data[0];
            CSR_SCAN_DIR:      cfg_in.scan_direction       = csr_write_data[0];
            CSR_DISPLAY_EN: begin
               cfg_in.display_enable = csr_write_data[0];
               clear_pins            = !csr_write_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.refresh_lag          <= LAG_RESET;
         cfg_ff.segment_active_level <= 1'b1;
         cfg_ff.digit_active_level   <= 1'b0;
         cfg_ff.scan_direction       <= 1'b0;
         cfg_ff.display_enable       <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ssd4_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_data   (push_data)
   );

   ssd4_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .pop_data  (pop_data)
   );

   ssd4_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .clear_pins      (clear_pins),
      .queue_not_empty (queue_not_empty),
      .queue_data      (pop_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload)
   );

endmodule

// File: rtl/core/ssd4_checker.sv
// Port-level checks for the seven-segment driver, bound to the top level.
// Depends on ssd4_pkg and seven_segment_four_digit_driver_core.
module ssd4_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input ssd4_pkg::rsp_payload_type rsp_payload
);
   import ssd4_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_payload))
      else $error("rsp payload changed while stalled");

   // at most one digit line active, whatever the polarity
   a_one_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($onehot0(rsp_payload.digit_pins) || $onehot0(~rsp_payload.digit_pins)))
      else $error("more than one digit enabled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not empty after reset");

endmodule

bind seven_segment_four_digit_driver_core ssd4_checker u_ssd4_checker (.*);
